@@ rtl/core/nearest_palette_color_search_defines.svh @@
// Assertion macros shared by the palette search RTL.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define NPCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define NPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/npcs_pkg.sv @@
`default_nettype none

package npcs_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF = 256;
  localparam int unsigned COLOR_W             = 8;
  localparam int unsigned INDEX_W             = 8;
  localparam int unsigned SQ_W                = 2 * COLOR_W;
  localparam int unsigned DIST_W              = SQ_W + 2;
  localparam int unsigned RGB_W               = 3 * COLOR_W;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } npcs_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } npcs_state_e;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                              input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/npcs_if.sv @@
`default_nettype none

interface npcs_in_if;
  import npcs_pkg::*;

  logic               valid;
  logic               ready;
  npcs_cmd_e          command;
  logic [INDEX_W-1:0] entry_index;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (
    output valid, command, entry_index, red, green, blue,
    input  ready
  );

  modport sink (
    input  valid, command, entry_index, red, green, blue,
    output ready
  );
endinterface

interface npcs_out_if;
  import npcs_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] best_index;

  modport source (
    output valid, best_index,
    input  ready
  );

  modport sink (
    input  valid, best_index,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/nearest_palette_color_search.sv @@
// Channel | Dir | Handshake     | Payload
// in_i    | in  | valid / ready | command, entry_index, red, green, blue
// out_o   | out | valid / ready | best_index
//
// A write transaction stores one palette entry when entry_index is below PALETTE_ENTRIES.
// A query reads the palette RAM one entry per cycle, then passes each entry
// through a squared-difference stage and a distance/compare stage.
// Reset clears control state only; the palette RAM is undefined until written.
// A query result waits in the output register; a new query can start while it
// waits but holds in its last step until the register is free.
`default_nettype none
`include "nearest_palette_color_search_defines.svh"

module nearest_palette_color_search #(
  parameter int unsigned PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  npcs_in_if.sink     in_i,
  npcs_out_if.source  out_o
);
  import npcs_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

  npcs_state_e state_q, state_d;

  logic [AW-1:0]      scan_addr_q, scan_addr_d;
  logic [COLOR_W-1:0] qry_r_q, qry_g_q, qry_b_q;

  logic               rd_vld_q, rd_last_q;
  logic [AW-1:0]      rd_idx_q;

  logic               sq_vld_q, sq_last_q;
  logic [AW-1:0]      sq_idx_q;
  logic [SQ_W-1:0]    sq_r_q, sq_g_q, sq_b_q;

  logic [DIST_W-1:0]  best_dist_q;
  logic [AW-1:0]      best_idx_q;
  logic               done_q;

  logic               out_valid_q;
  logic [INDEX_W-1:0] best_index_q;

  logic               in_ready;
  logic               in_fire;
  logic               idx_ok;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [RGB_W-1:0]   ram_wdata;
  logic [RGB_W-1:0]   ram_rdata;
  logic               out_free;
  logic               out_load;
  logic [DIST_W-1:0]  cand_dist;
  logic               take;

  assign in_ready  = (state_q == ST_IDLE);
  assign in_fire   = in_i.valid && in_ready;
  assign idx_ok    = ({1'b0, in_i.entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));
  assign ram_we    = in_fire && (in_i.command == CMD_WRITE) && idx_ok;
  assign ram_addr  = (state_q == ST_SCAN) ? scan_addr_q : in_i.entry_index[AW-1:0];
  assign ram_wdata = {in_i.red, in_i.green, in_i.blue};
  assign out_free  = !out_valid_q || out_o.ready;
  assign out_load  = (state_q == ST_DRAIN) && done_q && out_free;

  assign cand_dist = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);
  assign take = (sq_idx_q == '0) || (cand_dist < best_dist_q);

  npcs_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    scan_addr_d = scan_addr_q;
    case (state_q)
      ST_IDLE: begin
        scan_addr_d = '0;
        if (in_fire && (in_i.command == CMD_QUERY)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_addr_d = scan_addr_q + 1'b1;
        if (scan_addr_q == LAST_ADDR) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      sq_vld_q    <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_addr_q <= scan_addr_d;
      rd_vld_q    <= (state_q == ST_SCAN);
      sq_vld_q    <= rd_vld_q;
      if (out_load) begin
        done_q <= 1'b0;
      end else if (sq_vld_q && sq_last_q) begin
        done_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      qry_r_q <= in_i.red;
      qry_g_q <= in_i.green;
      qry_b_q <= in_i.blue;
    end
    rd_idx_q  <= scan_addr_q;
    rd_last_q <= (scan_addr_q == LAST_ADDR);
    sq_idx_q  <= rd_idx_q;
    sq_last_q <= rd_last_q;
    sq_r_q    <= sq_diff(qry_r_q, ram_rdata[3*COLOR_W-1:2*COLOR_W]);
    sq_g_q    <= sq_diff(qry_g_q, ram_rdata[2*COLOR_W-1:COLOR_W]);
    sq_b_q    <= sq_diff(qry_b_q, ram_rdata[COLOR_W-1:0]);
    if (sq_vld_q && take) begin
      best_dist_q <= cand_dist;
      best_idx_q  <= sq_idx_q;
    end
    if (out_load) begin
      best_index_q <= INDEX_W'(best_idx_q);
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.best_index = best_index_q;

  `NPCS_ASSERT(a_idle_pipe_empty, clk_i, rst_ni,
    (state_q == ST_IDLE) |-> !(rd_vld_q || sq_vld_q || done_q),
    "scan pipeline busy while idle")
  `NPCS_ASSERT(a_read_from_scan, clk_i, rst_ni,
    rd_vld_q |-> ($past(state_q) == ST_SCAN),
    "palette read data valid without a scan")
  `NPCS_ASSERT_NEXT(a_last_sets_done, clk_i, rst_ni,
    sq_vld_q && sq_last_q, done_q,
    "last distance did not complete the query")
  `NPCS_ASSERT(a_result_from_drain, clk_i, rst_ni,
    $rose(out_valid_q) |-> ($past(state_q) == ST_DRAIN),
    "result issued outside the drain step")

endmodule

`default_nettype wire

@@ rtl/core/npcs_ram.sv @@
`default_nettype none

module npcs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_nearest_palette_color_search.sv @@
`timescale 1ns / 100ps

module tb_nearest_palette_color_search;
  import npcs_pkg::*;

  localparam int unsigned ENTRIES    = PALETTE_ENTRIES_DEF;
  localparam int unsigned RAND_ITEMS = 1673;
  localparam int unsigned HOLD_LEN   = 700;

  typedef struct packed {
    npcs_cmd_e          cmd;
    logic [INDEX_W-1:0] idx;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               typed;
    logic [INDEX_W-1:0] best;
  } dir_row_t;

  // Palette starts as a gray ramp: entry i holds {i, i, i}.
  localparam int unsigned N_DIR = 21;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'd0},
    '{CMD_QUERY, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'd255},
    '{CMD_WRITE, 8'd200, 8'hff, 8'hff, 8'hff, 1'b0, 8'd0},
    '{CMD_QUERY, 8'h5a, 8'hff, 8'hff, 8'hff, 1'b1, 8'd200},
    '{CMD_WRITE, 8'd255, 8'h00, 8'hff, 8'h00, 1'b0, 8'd0},
    '{CMD_QUERY, 8'h00, 8'h00, 8'hff, 8'h00, 1'b1, 8'd255},
    '{CMD_WRITE, 8'd7, 8'h00, 8'h00, 8'hff, 1'b0, 8'd0},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 8'd7},
    '{CMD_WRITE, 8'd0, 8'hff, 8'h00, 8'h00, 1'b0, 8'd0},
    '{CMD_QUERY, 8'h80, 8'hff, 8'h00, 8'h00, 1'b1, 8'd0},
    '{CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0},
    '{CMD_WRITE, 8'd30, 8'h3c, 8'h3c, 8'h3c, 1'b0, 8'd0},
    '{CMD_QUERY, 8'h00, 8'h3c, 8'h3c, 8'h3c, 1'b1, 8'd30},
    '{CMD_QUERY, 8'h00, 8'h80, 8'h7f, 8'h80, 1'b0, 8'd0},
    '{CMD_QUERY, 8'h00, 8'h12, 8'h34, 8'h56, 1'b0, 8'd0},
    '{CMD_WRITE, 8'd128, 8'ha5, 8'h5a, 8'hc3, 1'b0, 8'd0},
    '{CMD_QUERY, 8'h00, 8'ha5, 8'h5a, 8'hc3, 1'b1, 8'd128},
    '{CMD_QUERY, 8'h00, 8'hfe, 8'h01, 8'hfe, 1'b0, 8'd0},
    '{CMD_QUERY, 8'h00, 8'hff, 8'hff, 8'h00, 1'b0, 8'd0},
    '{CMD_WRITE, 8'd200, 8'hc8, 8'hc8, 8'hc8, 1'b0, 8'd0},
    '{CMD_QUERY, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0, 8'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  npcs_in_if  in_if ();
  npcs_out_if out_if ();

  nearest_palette_color_search i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [RGB_W-1:0]   palette [ENTRIES];
  logic [INDEX_W-1:0] pending_best_q [$];
  int unsigned        mismatch_count;
  int unsigned        results_seen;
  bit                 steady;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [INDEX_W-1:0] nearest_entry(input logic [COLOR_W-1:0] r,
                                                       input logic [COLOR_W-1:0] g,
                                                       input logic [COLOR_W-1:0] b);
    int                 dr, dg, db;
    int unsigned        cand_dist, best_dist;
    logic [INDEX_W-1:0] best;
    best      = '0;
    best_dist = 0;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      dr        = int'(r) - int'(palette[i][23:16]);
      dg        = int'(g) - int'(palette[i][15:8]);
      db        = int'(b) - int'(palette[i][7:0]);
      cand_dist = int'(dr * dr + dg * dg + db * db);
      if (i == 0 || cand_dist < best_dist) begin
        best_dist = cand_dist;
        best      = INDEX_W'(i);
      end
    end
    return best;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 20) $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic issue_transaction(input npcs_cmd_e          cmd,
                                   input logic [INDEX_W-1:0] idx,
                                   input logic [COLOR_W-1:0] r,
                                   input logic [COLOR_W-1:0] g,
                                   input logic [COLOR_W-1:0] b,
                                   input logic               typed = 1'b0,
                                   input logic [INDEX_W-1:0] typed_best = '0);
    while (!steady && $urandom_range(99) < 12) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.entry_index <= idx;
    in_if.red         <= r;
    in_if.green       <= g;
    in_if.blue        <= b;
    do @(posedge clk_i); while (!in_if.ready);
    if (cmd == CMD_WRITE) begin
      palette[idx] = {r, g, b};
    end else begin
      pending_best_q.push_back(typed ? typed_best : nearest_entry(r, g, b));
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_best_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    logic [INDEX_W-1:0] want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_best_q.size() == 0) begin
        report_mismatch($sformatf("best_index %0d with no query pending", out_if.best_index));
      end else begin
        want = pending_best_q.pop_front();
        if (out_if.best_index !== want) begin
          report_mismatch($sformatf("best_index %0d, expected %0d", out_if.best_index, want));
        end
      end
    end
  end

  initial begin
    bit held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= 120) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
      end
      out_if.ready <= steady || ($urandom_range(99) >= 12);
    end
  end

  initial begin
    #60_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    npcs_cmd_e          cmd;
    logic [INDEX_W-1:0] ix;
    logic [COLOR_W-1:0] ri, gi, bi;
    int unsigned        mode;

    mismatch_count = 0;
    results_seen   = 0;
    steady         = 1'b0;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.command     <= CMD_WRITE;
    in_if.entry_index <= '0;
    in_if.red         <= '0;
    in_if.green       <= '0;
    in_if.blue        <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < ENTRIES; i++) begin
      issue_transaction(CMD_WRITE, INDEX_W'(i), COLOR_W'(i), COLOR_W'(i), COLOR_W'(i));
    end

    foreach (DIR_ROWS[n]) begin
      issue_transaction(DIR_ROWS[n].cmd, DIR_ROWS[n].idx, DIR_ROWS[n].red,
                        DIR_ROWS[n].green, DIR_ROWS[n].blue, DIR_ROWS[n].typed,
                        DIR_ROWS[n].best);
    end
    drain_results();

    for (int unsigned k = 0; k < RAND_ITEMS; k++) begin
      if (k == 800) drain_results();
      steady = (k >= 1000 && k < 1300);
      cmd  = ($urandom_range(99) < 40) ? CMD_QUERY : CMD_WRITE;
      ix   = INDEX_W'($urandom_range(255));
      mode = $urandom_range(99);
      if (mode < 25) begin
        // coarse grid: frequent ties between entries
        ri = COLOR_W'($urandom_range(3) * 85);
        gi = COLOR_W'($urandom_range(3) * 85);
        bi = COLOR_W'($urandom_range(3) * 85);
      end else if (mode < 45) begin
        {ri, gi, bi} = palette[$urandom_range(ENTRIES - 1)];
      end else if (mode < 55) begin
        ri = {COLOR_W{$urandom_range(1) == 1}};
        gi = {COLOR_W{$urandom_range(1) == 1}};
        bi = {COLOR_W{$urandom_range(1) == 1}};
      end else begin
        ri = COLOR_W'($urandom_range(255));
        gi = COLOR_W'($urandom_range(255));
        bi = COLOR_W'($urandom_range(255));
      end
      issue_transaction(cmd, ix, ri, gi, bi);
    end
    steady = 1'b0;

    drain_results();
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/npcs_pkg.sv
rtl/core/npcs_if.sv
rtl/core/npcs_ram.sv
rtl/core/nearest_palette_color_search.sv
tb/sv/tb_nearest_palette_color_search.sv
